@@ sv/kmlu_pkg.sv @@
// Shared constants, codes and types for the k-means Lloyd update core.
package kmlu_pkg;

   localparam int MAX_CLUSTERS_DEF = 8;
   localparam int MAX_DIMS_DEF     = 8;
   localparam int COUNT_BITS_DEF   = 20;
   localparam int COORD_W          = 32;
   localparam int DIST_W           = 64;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_POINT  = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   localparam logic KIND_ASSIGN   = 1'b0;
   localparam logic KIND_CENTROID = 1'b1;

   localparam logic REG_CLUSTERS = 1'b0;
   localparam logic REG_DIMS     = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_ADD,
      ST_ARGMIN,
      ST_ACCUM,
      ST_PEMIT,
      ST_FSEL,
      ST_DIV,
      ST_FEMIT,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic load;
      logic dist_add;
      logic dist_clr;
      logic acc;
      logic acc_last;
      logic store;
      logic sum_clr;
   } cell_ctrl_type;

endpackage

@@ sv/kmlu_req_if.sv @@
// Input channel: load, point and finish beats.
interface kmlu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [2:0]         cluster_index;
   logic [2:0]         dim_index;
   logic signed [31:0] coordinate;

   modport source (output valid, action, cluster_index, dim_index, coordinate, input ready);
   modport sink (input valid, action, cluster_index, dim_index, coordinate, output ready);
endinterface

@@ sv/kmlu_rsp_if.sv @@
// Result channel: assignments and new centroid coordinates.
interface kmlu_rsp_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [2:0]         cluster_out;
   logic [2:0]         dim_out;
   logic signed [31:0] centroid_value;
   logic               empty_cluster;
   logic               last;

   modport source (output valid, kind, cluster_out, dim_out, centroid_value, empty_cluster,
                   last, input ready);
   modport sink (input valid, kind, cluster_out, dim_out, centroid_value, empty_cluster,
                 last, output ready);
endinterface

@@ sv/kmlu_csr_if.sv @@
// Configuration write channel.
interface kmlu_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [3:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ sv/kmlu_cell.sv @@
// One cluster cell: centroid row, sums, count, distance and argmin link stage.
module kmlu_cell #(
   parameter int CELL_IDX   = 0,
   parameter int MAX_DIMS   = kmlu_pkg::MAX_DIMS_DEF,
   parameter int COUNT_BITS = kmlu_pkg::COUNT_BITS_DEF,
   parameter int CW         = 3,
   parameter int DW         = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kmlu_pkg::cell_ctrl_type       ctrl,
   input  logic [CW-1:0]                 tgt,
   input  logic [3:0]                    k,
   input  logic [DW-1:0]                 wdim,
   input  logic [DW-1:0]                 rdim,
   input  logic signed [31:0]            wr_value,
   input  logic signed [31:0]            coord,
   input  logic signed [31:0]            pbuf_value,
   input  logic [kmlu_pkg::DIST_W-1:0]   link_dist_in,
   input  logic [CW-1:0]                 link_idx_in,
   output logic [kmlu_pkg::DIST_W-1:0]   link_dist_out,
   output logic [CW-1:0]                 link_idx_out,
   output logic signed [COUNT_BITS+31:0] sum_rd,
   output logic [COUNT_BITS-1:0]         cnt_rd
);
   localparam int SUM_BITS = COUNT_BITS + 32;

   logic signed [31:0]         cent_ff [MAX_DIMS];
   logic signed [SUM_BITS-1:0] sum_ff [MAX_DIMS];
   logic [COUNT_BITS-1:0]      cnt_ff;
   logic [63:0]                sq_ff;
   logic [63:0]                dist_ff;
   logic [63:0]                link_dist_ff;
   logic [CW-1:0]              link_idx_ff;

   logic                       sel;
   logic                       active;
   logic signed [32:0]         diff;
   logic [31:0]                mag;
   logic [64:0]                dist_sum;
   logic signed [SUM_BITS:0]   acc_sum;
   logic signed [SUM_BITS-1:0] acc_in;

   assign sel    = (tgt == CW'(CELL_IDX));
   assign active = (32'(CELL_IDX) < 32'(k));
   assign diff   = 33'(coord) - 33'(cent_ff[rdim]);
   assign mag    = diff[32] ? 32'(-diff) : diff[31:0];
   assign dist_sum = 65'(dist_ff) + 65'(sq_ff);
   assign acc_sum  = (SUM_BITS+1)'(sum_ff[rdim]) + (SUM_BITS+1)'(pbuf_value);

   always_comb begin
      if (acc_sum[SUM_BITS] != acc_sum[SUM_BITS-1]) begin
         acc_in = acc_sum[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         acc_in = acc_sum[SUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= 64'(mag) * 64'(mag);
      if ((ctrl.load || ctrl.store) && sel) begin
         cent_ff[wdim] <= wr_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.sum_clr) begin
         for (int i = 0; i < MAX_DIMS; i++) begin
            sum_ff[i] <= '0;
         end
         cnt_ff <= '0;
      end else if (ctrl.acc && sel) begin
         sum_ff[rdim] <= acc_in;
         if (ctrl.acc_last && (cnt_ff != {COUNT_BITS{1'b1}})) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.dist_clr) begin
         dist_ff <= '0;
      end else if (ctrl.dist_add) begin
         dist_ff <= dist_sum[64] ? {64{1'b1}} : dist_sum[63:0];
      end
   end

   always_ff @(posedge clock) begin
      if (active && (dist_ff < link_dist_in)) begin
         link_dist_ff <= dist_ff;
         link_idx_ff  <= CW'(CELL_IDX);
      end else begin
         link_dist_ff <= link_dist_in;
         link_idx_ff  <= link_idx_in;
      end
   end

   assign link_dist_out = link_dist_ff;
   assign link_idx_out  = link_idx_ff;
   assign sum_rd        = sum_ff[rdim];
   assign cnt_rd        = cnt_ff;
endmodule

@@ sv/kmlu_div.sv @@
// Restoring divider, one quotient bit per cycle.
module kmlu_div #(
   parameter int COUNT_BITS = kmlu_pkg::COUNT_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [COUNT_BITS+31:0]    dividend,
   input  logic [COUNT_BITS-1:0]     divisor,
   output logic                      done,
   output logic [COUNT_BITS+31:0]    quo,
   output logic [COUNT_BITS-1:0]     rem
);
   localparam int SUM_BITS = COUNT_BITS + 32;
   localparam int SCW      = $clog2(SUM_BITS + 1);

   logic [SUM_BITS-1:0]   quo_ff;
   logic [COUNT_BITS:0]   rem_ff;
   logic [COUNT_BITS-1:0] dvs_ff;
   logic [SCW-1:0]        step_ff;
   logic                  done_ff;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;

   assign trial = {rem_ff[COUNT_BITS-1:0], quo_ff[SUM_BITS-1]};
   assign fits  = (trial >= (COUNT_BITS+1)'(dvs_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         step_ff <= SCW'(SUM_BITS);
         done_ff <= 1'b0;
      end else if (step_ff != '0) begin
         step_ff <= step_ff - 1'b1;
         done_ff <= (step_ff == SCW'(1));
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (step_ff != '0) begin
         quo_ff <= {quo_ff[SUM_BITS-2:0], fits};
         rem_ff <= fits ? trial - (COUNT_BITS+1)'(dvs_ff) : trial;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff[COUNT_BITS-1:0];
endmodule

@@ sv/kmeans_lloyd_update_core.sv @@
// Top level: sequencer, point buffer, cell chain, divider and result register.
// One Lloyd k-means pass in Q16.16. A load beat writes one centroid coordinate. A
// point coordinate is squared, then added, in every cell at once; the last
// coordinate of a point then lets the argmin ripple down the cell chain,
// accumulates into the winning cell one dimension at a time, and posts the
// assignment. After a finish beat is accepted, each emitted coordinate passes a
// select state, the shared divider for a non-empty cluster and an output state;
// a clear state then clears sums and counts. Results wait in a single output
// register; the sequencer stalls only when it must post a result while that
// register is still full.
module kmeans_lloyd_update_core #(
   parameter int MAX_CLUSTERS = kmlu_pkg::MAX_CLUSTERS_DEF,
   parameter int MAX_DIMS     = kmlu_pkg::MAX_DIMS_DEF,
   parameter int COUNT_BITS   = kmlu_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   kmlu_req_if.sink    req_bus,
   kmlu_rsp_if.source  rsp_bus,
   kmlu_csr_if.sink    csr_bus
);
   localparam int CW       = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int DW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int SUM_BITS = COUNT_BITS + 32;

   kmlu_pkg::state_type     state_ff, state_in;
   kmlu_pkg::cell_ctrl_type ctrl;

   logic [3:0]          cfg_k_ff, cfg_d_ff;
   logic [3:0]          k, dims;
   logic [DW-1:0]       pos_ff, d_ff;
   logic [CW-1:0]       j_ff, arg_ff, best_ff;
   logic signed [31:0]  coord_ff;
   logic signed [31:0]  pbuf_ff [MAX_DIMS];
   logic                neg_ff;
   logic signed [31:0]  mean_ff;
   logic                empty_ff;

   logic                rsp_valid_ff, rsp_kind_ff, rsp_empty_ff, rsp_last_ff;
   logic [2:0]          rsp_cluster_ff, rsp_dim_ff;
   logic signed [31:0]  rsp_value_ff;

   logic                req_fire, out_free, pos_last, d_last, j_last, load_ok;
   logic [CW-1:0]       tgt;
   logic [DW-1:0]       wdim, rdim;
   logic signed [31:0]  wr_value;

   logic [63:0]         link_dist [MAX_CLUSTERS+1];
   logic [CW-1:0]       link_idx [MAX_CLUSTERS+1];
   logic signed [SUM_BITS-1:0] sum_rd [MAX_CLUSTERS];
   logic [COUNT_BITS-1:0]      cnt_rd [MAX_CLUSTERS];
   logic signed [SUM_BITS-1:0] sum_sel;
   logic [COUNT_BITS-1:0]      cnt_sel;

   logic                div_start, div_done;
   logic [SUM_BITS-1:0] div_quo;
   logic [COUNT_BITS-1:0] div_rem;
   logic [SUM_BITS-1:0] sum_mag;
   logic [SUM_BITS:0]   q_round;
   logic                round_up;
   logic signed [31:0]  mean_in;

   assign k    = (cfg_k_ff == 4'd0) ? 4'd1 :
                 ((32'(cfg_k_ff) > MAX_CLUSTERS) ? 4'(MAX_CLUSTERS) : cfg_k_ff);
   assign dims = (cfg_d_ff == 4'd0) ? 4'd1 :
                 ((32'(cfg_d_ff) > MAX_DIMS) ? 4'(MAX_DIMS) : cfg_d_ff);

   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_k_ff <= 4'd8;
         cfg_d_ff <= 4'd8;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            kmlu_pkg::REG_CLUSTERS: cfg_k_ff <= csr_bus.data;
            kmlu_pkg::REG_DIMS:     cfg_d_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign req_bus.ready = (state_ff == kmlu_pkg::ST_IDLE);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign pos_last = (32'(pos_ff) + 32'd1) >= 32'(dims);
   assign d_last   = (32'(d_ff) + 32'd1) == 32'(dims);
   assign j_last   = (32'(j_ff) + 32'd1) == 32'(k);
   assign load_ok  = (32'(req_bus.cluster_index) < MAX_CLUSTERS) &&
                     (32'(req_bus.dim_index) < MAX_DIMS);

   assign sum_sel = sum_rd[j_ff];
   assign cnt_sel = cnt_rd[j_ff];
   assign sum_mag = sum_sel[SUM_BITS-1] ? SUM_BITS'(-sum_sel) : SUM_BITS'(sum_sel);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kmlu_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_bus.action)
                  kmlu_pkg::ACT_POINT:  state_in = kmlu_pkg::ST_SQ;
                  kmlu_pkg::ACT_FINISH: state_in = kmlu_pkg::ST_FSEL;
                  default:              state_in = kmlu_pkg::ST_IDLE;
               endcase
            end
         end
         kmlu_pkg::ST_SQ:     state_in = kmlu_pkg::ST_ADD;
         kmlu_pkg::ST_ADD:    state_in = pos_last ? kmlu_pkg::ST_ARGMIN : kmlu_pkg::ST_IDLE;
         kmlu_pkg::ST_ARGMIN: begin
            if (32'(arg_ff) == MAX_CLUSTERS - 1) state_in = kmlu_pkg::ST_ACCUM;
         end
         kmlu_pkg::ST_ACCUM:  if (d_last) state_in = kmlu_pkg::ST_PEMIT;
         kmlu_pkg::ST_PEMIT:  if (out_free) state_in = kmlu_pkg::ST_IDLE;
         kmlu_pkg::ST_FSEL:   state_in = (cnt_sel == '0) ? kmlu_pkg::ST_FEMIT : kmlu_pkg::ST_DIV;
         kmlu_pkg::ST_DIV:    if (div_done) state_in = kmlu_pkg::ST_FEMIT;
         kmlu_pkg::ST_FEMIT: begin
            if (out_free) state_in = (j_last && d_last) ? kmlu_pkg::ST_CLEAR : kmlu_pkg::ST_FSEL;
         end
         kmlu_pkg::ST_CLEAR:  state_in = kmlu_pkg::ST_IDLE;
         default:             state_in = kmlu_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl      = '0;
      div_start = 1'b0;
      tgt       = j_ff;
      wdim      = d_ff;
      rdim      = d_ff;
      wr_value  = mean_ff;
      case (state_ff)
         kmlu_pkg::ST_IDLE: begin
            tgt      = CW'(req_bus.cluster_index);
            wdim     = DW'(req_bus.dim_index);
            wr_value = req_bus.coordinate;
            ctrl.load = req_fire && (req_bus.action == kmlu_pkg::ACT_LOAD) && load_ok;
            ctrl.dist_clr = req_fire && (req_bus.action == kmlu_pkg::ACT_FINISH);
         end
         kmlu_pkg::ST_SQ:    rdim = pos_ff;
         kmlu_pkg::ST_ADD:   ctrl.dist_add = 1'b1;
         kmlu_pkg::ST_ACCUM: begin
            tgt           = link_idx[MAX_CLUSTERS];
            ctrl.acc      = 1'b1;
            ctrl.acc_last = d_last;
         end
         kmlu_pkg::ST_PEMIT: ctrl.dist_clr = out_free;
         kmlu_pkg::ST_FSEL:  div_start = (cnt_sel != '0);
         kmlu_pkg::ST_FEMIT: ctrl.store = out_free;
         kmlu_pkg::ST_CLEAR: ctrl.sum_clr = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kmlu_pkg::ST_IDLE;
         pos_ff   <= '0;
         d_ff     <= '0;
         j_ff     <= '0;
         arg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            kmlu_pkg::ST_IDLE: begin
               if (req_fire && (req_bus.action == kmlu_pkg::ACT_FINISH)) begin
                  pos_ff <= '0;
                  d_ff   <= '0;
                  j_ff   <= '0;
               end
            end
            kmlu_pkg::ST_ADD: begin
               arg_ff <= '0;
               d_ff   <= '0;
               if (!pos_last) pos_ff <= pos_ff + 1'b1;
            end
            kmlu_pkg::ST_ARGMIN: arg_ff <= arg_ff + 1'b1;
            kmlu_pkg::ST_ACCUM:  d_ff <= d_ff + 1'b1;
            kmlu_pkg::ST_PEMIT:  if (out_free) pos_ff <= '0;
            kmlu_pkg::ST_FEMIT: begin
               if (out_free) begin
                  if (d_last) begin
                     d_ff <= '0;
                     j_ff <= j_ff + 1'b1;
                  end else begin
                     d_ff <= d_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && (req_bus.action == kmlu_pkg::ACT_POINT)) begin
         coord_ff        <= req_bus.coordinate;
         pbuf_ff[pos_ff] <= req_bus.coordinate;
      end
      if (state_ff == kmlu_pkg::ST_ACCUM) best_ff <= link_idx[MAX_CLUSTERS];
      if (state_ff == kmlu_pkg::ST_FSEL) begin
         neg_ff   <= sum_sel[SUM_BITS-1];
         mean_ff  <= '0;
         empty_ff <= (cnt_sel == '0);
      end else if ((state_ff == kmlu_pkg::ST_DIV) && div_done) begin
         mean_ff <= mean_in;
      end
   end

   assign round_up = ({1'b0, div_rem} << 1) >= (COUNT_BITS+1)'(cnt_sel);
   assign q_round  = (SUM_BITS+1)'(div_quo) + (SUM_BITS+1)'(round_up);

   always_comb begin
      if (neg_ff) begin
         mean_in = (q_round > (SUM_BITS+1)'(33'h080000000)) ? 32'sh80000000 : -q_round[31:0];
      end else begin
         mean_in = (q_round > (SUM_BITS+1)'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : q_round[31:0];
      end
   end

   kmlu_div #(.COUNT_BITS(COUNT_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (cnt_sel),
      .done     (div_done),
      .quo      (div_quo),
      .rem      (div_rem)
   );

   assign link_dist[0] = {64{1'b1}};
   assign link_idx[0]  = '0;

   for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
      kmlu_cell #(
         .CELL_IDX   (g),
         .MAX_DIMS   (MAX_DIMS),
         .COUNT_BITS (COUNT_BITS),
         .CW         (CW),
         .DW         (DW)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .tgt           (tgt),
         .k             (k),
         .wdim          (wdim),
         .rdim          (rdim),
         .wr_value      (wr_value),
         .coord         (coord_ff),
         .pbuf_value    (pbuf_ff[d_ff]),
         .link_dist_in  (link_dist[g]),
         .link_idx_in   (link_idx[g]),
         .link_dist_out (link_dist[g+1]),
         .link_idx_out  (link_idx[g+1]),
         .sum_rd        (sum_rd[g]),
         .cnt_rd        (cnt_rd[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == kmlu_pkg::ST_PEMIT || state_ff == kmlu_pkg::ST_FEMIT) &&
                   out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == kmlu_pkg::ST_PEMIT) && out_free) begin
         rsp_kind_ff    <= kmlu_pkg::KIND_ASSIGN;
         rsp_cluster_ff <= 3'(best_ff);
         rsp_dim_ff     <= '0;
         rsp_value_ff   <= '0;
         rsp_empty_ff   <= 1'b0;
         rsp_last_ff    <= 1'b1;
      end else if ((state_ff == kmlu_pkg::ST_FEMIT) && out_free) begin
         rsp_kind_ff    <= kmlu_pkg::KIND_CENTROID;
         rsp_cluster_ff <= 3'(j_ff);
         rsp_dim_ff     <= 3'(d_ff);
         rsp_value_ff   <= mean_ff;
         rsp_empty_ff   <= empty_ff;
         rsp_last_ff    <= j_last && d_last;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.kind           = rsp_kind_ff;
   assign rsp_bus.cluster_out    = rsp_cluster_ff;
   assign rsp_bus.dim_out        = rsp_dim_ff;
   assign rsp_bus.centroid_value = rsp_value_ff;
   assign rsp_bus.empty_cluster  = rsp_empty_ff;
   assign rsp_bus.last           = rsp_last_ff;
endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the k-means Lloyd update core.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 8000;
   localparam int SETTLE     = 40;
   localparam int ITEM_GOAL  = 370;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic        kind;
      logic [2:0]  cluster;
      logic [2:0]  dim;
      logic [31:0] value;
      logic        empty;
      logic        last;
   } kmeans_beat_type;

   class kmeans_scoreboard;
      logic signed [31:0] centroid[8][8];
      longint             sums[8][8];
      int unsigned        counts[8];
      logic [63:0]        part_dist[8];
      logic signed [31:0] point[8];
      int unsigned        pos;
      logic [3:0]         k_reg, d_reg;
      kmeans_beat_type    pending_q[$];
      int                 errors;

      function new();
         foreach (sums[j, d]) begin
            sums[j][d] = 0;
            centroid[j][d] = '0;
         end
         foreach (counts[j]) begin
            counts[j] = 0;
            part_dist[j] = '0;
            point[j] = '0;
         end
         pos = 0;
         k_reg = 4'd8;
         d_reg = 4'd8;
         errors = 0;
      endfunction

      function int unsigned clamp(logic [3:0] v);
         if (v < 1) return 1;
         if (v > 8) return 8;
         return v;
      endfunction

      function int unsigned dims_eff();
         return clamp(d_reg);
      endfunction

      function void write_reg(logic idx, logic [3:0] val);
         if (idx == kmlu_pkg::REG_CLUSTERS) k_reg = val;
         else d_reg = val;
      endfunction

      function void push(logic kind, int c, int d, logic [31:0] v, logic e, logic l);
         kmeans_beat_type b;
         b.kind = kind; b.cluster = 3'(c); b.dim = 3'(d); b.value = v; b.empty = e;
         b.last = l;
         pending_q.push_back(b);
      endfunction

      function longint sat_add(longint a, longint b);
         longint hi, lo;
         hi = (longint'(1) <<< 51) - 1;
         lo = -hi - 1;
         if (b > 0 && a > hi - b) return hi;
         if (b < 0 && a < lo - b) return lo;
         return a + b;
      endfunction

      function logic [31:0] mean(longint s, int unsigned n);
         longint unsigned mag, q, r;
         mag = s < 0 ? -s : s;
         q = mag / n;
         r = mag % n;
         if (2 * r >= n) q++;
         if (s < 0) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(-longint'(q));
         end
         if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
         return 32'(q);
      endfunction

      function void clear_pass();
         foreach (part_dist[j]) part_dist[j] = '0;
         pos = 0;
      endfunction

      function void note_input(logic [1:0] act, logic [2:0] ci, logic [2:0] di,
                               logic signed [31:0] coord);
         int unsigned k, dims, best, n;
         longint diff;
         logic [63:0] mag, sq;
         k = clamp(k_reg);
         dims = clamp(d_reg);
         case (act)
            kmlu_pkg::ACT_LOAD: centroid[ci][di] = coord;
            kmlu_pkg::ACT_POINT: begin
               if (pos < 8) begin
                  point[pos] = coord;
                  for (int j = 0; j < k; j++) begin
                     diff = longint'(coord) - longint'(centroid[j][pos]);
                     mag = diff < 0 ? -diff : diff;
                     sq = mag * mag;
                     part_dist[j] = (part_dist[j] > ~sq) ? '1 : part_dist[j] + sq;
                  end
               end
               pos++;
               if (pos >= dims) begin
                  best = 0;
                  for (int j = 1; j < k; j++)
                     if (part_dist[j] < part_dist[best]) best = j;
                  for (int d = 0; d < dims; d++)
                     sums[best][d] = sat_add(sums[best][d], longint'(point[d]));
                  if (counts[best] < 20'hFFFFF) counts[best]++;
                  clear_pass();
                  push(kmlu_pkg::KIND_ASSIGN, best, 0, '0, 1'b0, 1'b1);
               end
            end
            kmlu_pkg::ACT_FINISH: begin
               n = 0;
               for (int j = 0; j < k; j++)
                  for (int d = 0; d < dims; d++) begin
                     centroid[j][d] = counts[j] ? mean(sums[j][d], counts[j]) : '0;
                     n++;
                     push(kmlu_pkg::KIND_CENTROID, j, d, centroid[j][d], counts[j] == 0,
                          n == k * dims);
                  end
               foreach (sums[j, d]) sums[j][d] = 0;
               foreach (counts[j]) counts[j] = 0;
               clear_pass();
            end
            default: ;
         endcase
      endfunction

      function void field(string name, logic [31:0] e, logic [31:0] a);
         if (e !== a) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            errors++;
         end
      endfunction

      function void check_result(kmeans_beat_type got);
         kmeans_beat_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result beat, actual cluster %0d value %0h",
                     $time, got.cluster, got.value);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         field("kind", e.kind, got.kind);
         field("cluster_out", e.cluster, got.cluster);
         field("dim_out", e.dim, got.dim);
         field("centroid_value", e.value, got.value);
         field("empty_cluster", e.empty, got.empty);
         field("last", e.last, got.last);
      endfunction
   endclass

   logic clock, reset;
   kmlu_req_if req_bus();
   kmlu_rsp_if rsp_bus();
   kmlu_csr_if csr_bus();

   kmeans_lloyd_update_core uut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   kmeans_scoreboard sb = new();
   int  items = 0;
   int  idle_cycles = 0;
   int  rx_wait = 0;
   int  rx_hold = 0;
   bit  rx_quiet = 0;
   bit  tx_quiet = 0;

   initial clock = 0;
   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      kmeans_beat_type b;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         b.kind = rsp_bus.kind; b.cluster = rsp_bus.cluster_out; b.dim = rsp_bus.dim_out;
         b.value = rsp_bus.centroid_value; b.empty = rsp_bus.empty_cluster;
         b.last = rsp_bus.last;
         sb.check_result(b);
         rx_wait = rx_quiet ? 0 : $urandom_range(0, 4);
      end
   end

   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_bus.ready <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait--;
         rsp_bus.ready <= 1'b0;
      end else
         rsp_bus.ready <= 1'b1;
   end

   task automatic send(logic [1:0] act, logic [2:0] ci, logic [2:0] di, logic [31:0] c);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= act;
      req_bus.cluster_index <= ci;
      req_bus.dim_index <= di;
      req_bus.coordinate <= c;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_input(act, ci, di, c);
      items++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.pending_q.size() > 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [3:0] val);
      settle();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      endcase
   endfunction

   task automatic send_point();
      int n;
      n = sb.dims_eff();
      for (int d = 0; d < n; d++) send(kmlu_pkg::ACT_POINT, 3'd0, 3'd0, rand_coord());
   endtask

   initial begin
      int npts;
      req_bus.valid = 1'b0; req_bus.action = kmlu_pkg::ACT_LOAD; req_bus.cluster_index = '0;
      req_bus.dim_index = '0; req_bus.coordinate = '0;
      csr_bus.valid = 1'b0; csr_bus.index = kmlu_pkg::REG_CLUSTERS; csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // clusters 0 and 1 identical at the positive extreme: saturated tie
      for (int j = 0; j < 8; j++)
         for (int d = 0; d < 8; d++)
            send(kmlu_pkg::ACT_LOAD, 3'(j), 3'(d), j < 2 ? 32'h7FFF_FFFF : rand_coord());
      for (int d = 0; d < 8; d++) send(kmlu_pkg::ACT_POINT, 3'd0, 3'd0, 32'h8000_0000);
      for (int d = 0; d < 8; d++) send(kmlu_pkg::ACT_POINT, 3'd0, 3'd0, 32'h7FFF_FFFF);
      send(ACT_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
      send_point();
      send(kmlu_pkg::ACT_POINT, 3'd0, 3'd0, 32'h0000_0001);
      send(kmlu_pkg::ACT_FINISH, 3'd0, 3'd0, '0);

      write_reg(kmlu_pkg::REG_CLUSTERS, 4'd0);
      write_reg(kmlu_pkg::REG_DIMS, 4'd15);
      send_point();
      send(kmlu_pkg::ACT_FINISH, 3'd0, 3'd0, '0);
      write_reg(kmlu_pkg::REG_CLUSTERS, 4'd15);
      write_reg(kmlu_pkg::REG_DIMS, 4'd0);
      repeat (4) send_point();
      send(kmlu_pkg::ACT_FINISH, 3'd0, 3'd0, '0);

      // shrink dims while a point is half done
      write_reg(kmlu_pkg::REG_DIMS, 4'd8);
      repeat (5) send(kmlu_pkg::ACT_POINT, 3'd0, 3'd0, rand_coord());
      write_reg(kmlu_pkg::REG_DIMS, 4'd3);
      send(kmlu_pkg::ACT_POINT, 3'd0, 3'd0, rand_coord());
      send(kmlu_pkg::ACT_FINISH, 3'd0, 3'd0, '0);

      // output backs up while the sender keeps offering
      write_reg(kmlu_pkg::REG_CLUSTERS, 4'd4);
      write_reg(kmlu_pkg::REG_DIMS, 4'd1);
      tx_quiet = 1;
      rx_hold = 300;
      repeat (12) send_point();
      tx_quiet = 0;
      send(kmlu_pkg::ACT_FINISH, 3'd0, 3'd0, '0);

      while (items < ITEM_GOAL) begin
         write_reg(kmlu_pkg::REG_CLUSTERS, $urandom_range(0, 3) == 0 ? 4'($urandom()) :
                                 4'($urandom_range(1, 4)));
         write_reg(kmlu_pkg::REG_DIMS, $urandom_range(0, 3) == 0 ? 4'($urandom()) :
                             4'($urandom_range(1, 3)));
         tx_quiet = $urandom_range(0, 3) == 0;
         rx_quiet = $urandom_range(0, 3) == 0;
         npts = $urandom_range(3, 12);
         for (int p = 0; p < npts; p++) begin
            if (items >= ITEM_GOAL) break;
            case ($urandom_range(0, 9))
               0: send(ACT_UNUSED, 3'($urandom()), 3'($urandom()), $urandom());
               1: send(kmlu_pkg::ACT_LOAD, 3'($urandom()), 3'($urandom()), rand_coord());
               2: send(kmlu_pkg::ACT_POINT, 3'd0, 3'd0, rand_coord());
               default: send_point();
            endcase
         end
         if ($urandom_range(0, 7) == 0) send(kmlu_pkg::ACT_POINT, 3'd0, 3'd0, rand_coord());
         send(kmlu_pkg::ACT_FINISH, 3'd0, 3'd0, '0);
      end

      settle();
      repeat (100) @(negedge clock);
      if (sb.pending_q.size() > 0)
         $display("%0t: %0d expected result beats never arrived",
                  $time, sb.pending_q.size());
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

@@ filelist.f @@
sv/kmlu_pkg.sv
sv/kmlu_req_if.sv
sv/kmlu_rsp_if.sv
sv/kmlu_csr_if.sv
sv/kmlu_cell.sv
sv/kmlu_div.sv
sv/kmeans_lloyd_update_core.sv
verif/testbench.sv
